// ===== sv/scpu_pkg.sv =====
package scpu_pkg;

  localparam int unsigned Xlen     = 32;
  localparam int unsigned RegCount = 32;
  localparam int unsigned RegAw    = $clog2(RegCount);
  localparam int unsigned OpcW     = 6;
  localparam int unsigned DivCntW  = $clog2(Xlen);

  typedef logic [Xlen-1:0]  word_t;
  typedef logic [RegAw-1:0] reg_idx_t;

  typedef enum logic [OpcW-1:0] {
    OPC_STORE  = 6'd1,
    OPC_ADD    = 6'd2,
    OPC_SUB    = 6'd3,
    OPC_SLT    = 6'd4,
    OPC_MOD    = 6'd5,
    OPC_JUMP   = 6'd6,
    OPC_BEQ    = 6'd7,
    OPC_BNE    = 6'd8,
    OPC_REGOUT = 6'd9,
    OPC_SAVE   = 6'd10,
    OPC_LOAD   = 6'd11
  } opcode_t;

  typedef struct packed {
    logic ir_load;
    logic rf_read;
    logic commit;
    logic div_start;
    logic div_step;
    logic div_wb;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic need_div;
    logic div_last;
  } status_t;

endpackage

// ===== sv/scpu_ctrl.sv =====
module scpu_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  output logic               out_valid,
  input  logic               out_stall,
  input  scpu_pkg::status_t  status,
  output scpu_pkg::cmd_t     cmd
);
  import scpu_pkg::*;

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_DEC  = 6'b000010,
    ST_EXEC = 6'b000100,
    ST_DIV  = 6'b001000,
    ST_MWB  = 6'b010000,
    ST_FIN  = 6'b100000
  } state_t;

  state_t state, state_next;
  logic   out_free;

  assign in_stall = (state != ST_IDLE);
  assign out_free = !out_valid || !out_stall;

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.ir_load = 1'b1;
          state_next  = ST_DEC;
        end
      end
      ST_DEC: begin
        cmd.rf_read = 1'b1;
        state_next  = ST_EXEC;
      end
      ST_EXEC: begin
        if (status.need_div) begin
          cmd.div_start = 1'b1;
          state_next    = ST_DIV;
        end else begin
          cmd.commit = 1'b1;
          state_next = ST_FIN;
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (status.div_last) begin
          state_next = ST_MWB;
        end
      end
      ST_MWB: begin
        cmd.div_wb = 1'b1;
        state_next = ST_FIN;
      end
      ST_FIN: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// ===== sv/scpu_dp.sv =====
module scpu_dp (
  input  logic               clk,
  input  logic               rst,
  input  scpu_pkg::cmd_t     cmd,
  output scpu_pkg::status_t  status,
  input  scpu_pkg::word_t    instruction_word,
  output scpu_pkg::word_t    fetch_pc,
  output logic               print_valid,
  output scpu_pkg::word_t    print_value,
  output logic               halted
);
  import scpu_pkg::*;

  word_t           ir;
  opcode_t         opc;
  reg_idx_t        rs, rt, rd;
  word_t           rf [RegCount];
  logic [RegCount-1:0] rf_vld;
  word_t           a_q, b_q, a, b;
  logic            a_vld, b_vld;
  logic            rf_we;
  word_t           rf_wd;

  word_t           pc, pc_next, seq;
  word_t           mem, mem_next;
  logic            halt_q, halt_next;
  logic            pvv, pvv_next;
  word_t           pv, pv_next;

  word_t           rem, quo;
  logic [DivCntW-1:0] cnt;
  logic [Xlen+1:0] trial;

  assign opc = opcode_t'(ir[Xlen-1 -: OpcW]);
  assign rs  = ir[25:21];
  assign rt  = ir[20:16];
  assign rd  = ir[15:11];
  assign a   = a_vld ? a_q : '0;
  assign b   = b_vld ? b_q : '0;
  assign seq = pc + Xlen'(4);

  always_ff @(posedge clk) begin
    if (cmd.ir_load) begin
      ir <= instruction_word;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rf_read) begin
      a_q   <= rf[rs];
      b_q   <= rf[rt];
      a_vld <= rf_vld[rs];
      b_vld <= rf_vld[rt];
    end
    if (rf_we) begin
      rf[rd] <= rf_wd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rf_vld <= '0;
    end else if (rf_we) begin
      rf_vld[rd] <= 1'b1;
    end
  end

  assign status.need_div = !halt_q && (ir != '0) && (opc == OPC_MOD) && (b != '0);
  assign status.div_last = (cnt == '1);

  assign trial = {1'b0, rem, quo[Xlen-1]} - {2'b00, b};

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      rem <= '0;
      quo <= a;
      cnt <= '0;
    end else if (cmd.div_step) begin
      if (!trial[Xlen+1]) begin
        rem <= trial[Xlen-1:0];
      end else begin
        rem <= {rem[Xlen-2:0], quo[Xlen-1]};
      end
      quo <= {quo[Xlen-2:0], !trial[Xlen+1]};
      cnt <= cnt + DivCntW'(1);
    end
  end

  always_comb begin
    rf_we     = 1'b0;
    rf_wd     = '0;
    pc_next   = pc;
    mem_next  = mem;
    halt_next = halt_q;
    pvv_next  = pvv;
    pv_next   = pv;
    if (cmd.commit) begin
      pvv_next = 1'b0;
      pv_next  = '0;
      if (!halt_q) begin
        if (ir == '0) begin
          halt_next = 1'b1;
        end else begin
          pc_next = seq;
          unique case (opc)
            OPC_STORE: begin
              rf_we = 1'b1;
              rf_wd = Xlen'({rs, rt});
            end
            OPC_ADD: begin
              rf_we = 1'b1;
              rf_wd = a + b;
            end
            OPC_SUB: begin
              rf_we = 1'b1;
              rf_wd = a - b;
            end
            OPC_SLT: begin
              rf_we = 1'b1;
              rf_wd = Xlen'(a < b);
            end
            OPC_MOD: begin
              rf_we = 1'b1;
              rf_wd = a;
            end
            OPC_JUMP: begin
              pc_next = {seq[Xlen-1 -: 4], ir[25:0], 2'b00};
            end
            OPC_BEQ: begin
              if (a == b) begin
                pc_next = Xlen'(ir[15:0]);
              end
            end
            OPC_BNE: begin
              if (a != b) begin
                pc_next = Xlen'(ir[15:0]);
              end
            end
            OPC_REGOUT: begin
              pvv_next = 1'b1;
              pv_next  = a;
            end
            OPC_SAVE: begin
              mem_next = a;
            end
            OPC_LOAD: begin
              rf_we = 1'b1;
              rf_wd = mem;
            end
            default: begin
            end
          endcase
        end
      end
    end else if (cmd.div_wb) begin
      rf_we    = 1'b1;
      rf_wd    = rem;
      pc_next  = seq;
      pvv_next = 1'b0;
      pv_next  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc     <= '0;
      mem    <= '0;
      halt_q <= 1'b0;
      pvv    <= 1'b0;
      pv     <= '0;
    end else begin
      pc     <= pc_next;
      mem    <= mem_next;
      halt_q <= halt_next;
      pvv    <= pvv_next;
      pv     <= pv_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      fetch_pc    <= pc;
      print_valid <= pvv;
      print_value <= pv;
      halted      <= halt_q;
    end
  end

  a_halt_sticky: assert property (@(posedge clk) disable iff (rst)
    halt_q |=> halt_q)
    else $error("halt flag cleared while running");

  a_halt_frozen: assert property (@(posedge clk) disable iff (rst)
    cmd.commit && halt_q |=> $stable(pc) && $stable(mem) && !pvv)
    else $error("state changed while halted");

  a_div_order: assert property (@(posedge clk) disable iff (rst)
    cmd.div_wb |-> $past(cmd.div_step) && $past(status.div_last))
    else $error("remainder written before divider finished");

endmodule

// ===== sv/small_cpu_instruction_step_top.sv =====
// Steps: the input beat is taken in IDLE, then DEC, EXEC, for MOD with a nonzero divisor DIV and MWB, then FIN.
// Throughput: one instruction at a time; a MOD with a nonzero divisor runs through the
// bit-serial divider, which retires one quotient bit per cycle.
// A finished result waits in the output register while the next beat is taken.
// Reset (synchronous, active high): registers read as zero, PC, memory word and halt cleared.
module small_cpu_instruction_step_top (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  scpu_pkg::word_t  instruction_word,
  output logic             out_valid,
  input  logic             out_stall,
  output scpu_pkg::word_t  fetch_pc,
  output logic             print_valid,
  output scpu_pkg::word_t  print_value,
  output logic             halted
);
  import scpu_pkg::*;

  cmd_t    cmd;
  status_t status;

  scpu_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  scpu_dp u_dp (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .status           (status),
    .instruction_word (instruction_word),
    .fetch_pc         (fetch_pc),
    .print_valid      (print_valid),
    .print_value      (print_value),
    .halted           (halted)
  );

endmodule
